// ===== src/emarif_pkg.sv =====
package emarif_pkg;

    localparam int DATA_W   = 32;
    localparam int W_W      = 17;               // Q0.16 weight incl. the value 1.0
    localparam int DIV_N_W  = 49;               // divider numerator width
    localparam int DIV_D_W  = 32;               // divider denominator width
    localparam int ACC_W    = 51;               // weighted sum accumulator
    localparam int MUL_A_W  = 37;
    localparam int MUL_B_W  = 33;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic [W_W-1:0]  WONE          = 17'd65536;
    localparam logic [31:0]     Q31ONE        = 32'h8000_0000;
    localparam logic [29:0]     EXP_M1_Q31    = 30'd790015084;
    localparam logic [3:0]      EXP_INT_LIMIT = 4'd12;
    localparam logic [3:0]      HORNER_TERMS  = 4'd8;

    // register indexes
    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_SMOOTHING = 1'b1;

    // reciprocal ceil(2^35 / k), so floor(p / k) = (p * m) >> 35 for p < 2^32
    function automatic logic [35:0] recip_k(input logic [3:0] k);
        logic [35:0] m;
        case (k)
            4'd1:    m = 36'd34359738368;
            4'd2:    m = 36'd17179869184;
            4'd3:    m = 36'd11453246123;
            4'd4:    m = 36'd8589934592;
            4'd5:    m = 36'd6871947674;
            4'd6:    m = 36'd5726623062;
            4'd7:    m = 36'd4908534053;
            4'd8:    m = 36'd4294967296;
            default: m = 36'd0;
        endcase
        return m;
    endfunction

    // drop 16 fraction bits rounding half up, then saturate to 32 bits
    function automatic logic [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-17:0] r;
        logic [DATA_W-1:0] o;
        b = s + 51'sd32768;
        r = b[ACC_W-1:16];
        if (r > 35'sd2147483647)
            o = 32'h7FFF_FFFF;
        else if (r < -35'sd2147483648)
            o = 32'h8000_0000;
        else
            o = r[DATA_W-1:0];
        return o;
    endfunction

endpackage

// ===== src/emarif_div.sv =====
module emarif_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [emarif_pkg::DIV_N_W-1:0]     dividend,
    input  logic [emarif_pkg::DIV_D_W-1:0]     divisor,
    output logic                               done,
    output logic [emarif_pkg::DIV_N_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(emarif_pkg::DIV_N_W + 1);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [emarif_pkg::DIV_N_W-1:0]    q_reg, q_next;
    logic [emarif_pkg::DIV_D_W-1:0]    rem_reg, rem_next;
    logic [emarif_pkg::DIV_D_W-1:0]    dvs_reg, dvs_next;
    logic [emarif_pkg::DIV_D_W:0]      sh;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        sh        = {rem_reg, q_reg[emarif_pkg::DIV_N_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(emarif_pkg::DIV_N_W);
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (sh >= {1'b0, dvs_reg})
            begin
                rem_next = emarif_pkg::DIV_D_W'(sh - {1'b0, dvs_reg});
                q_next   = {q_reg[emarif_pkg::DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = sh[emarif_pkg::DIV_D_W-1:0];
                q_next   = {q_reg[emarif_pkg::DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg != CNT_W'(1) |=> busy_reg)
        else $error("divider stopped early");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < dvs_reg)
        else $error("divider remainder out of range");

endmodule

// ===== src/ema_regular_irregular_filter_top.sv =====
// Exponential moving average, regular and irregular time-spaced series.
// First sample, zero time step and zero tau go straight to the output; regular mode uses the
// shared multiplier only; irregular mode runs two divisions, 8 Horner steps and up to 11
// exp(-1) steps, or skips Horner and exp(-1) when u >= 12 gives w = 0. One request at a
// time: with the shared divider and multiplier, a new one is taken once the last result is output.
// Reset (asynchronous, active low): mode regular, smoothing 0.5, state cleared, unseeded.
module ema_regular_irregular_filter_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sample,
    input  logic        [31:0] timestamp,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] average,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic        [31:0] cfg_data
);

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_M0   = 5'd1;   // coef0 * sample
    localparam logic [4:0] S_M1   = 5'd2;   // coef1 * average
    localparam logic [4:0] S_M2   = 5'd3;   // coef2 * previous sample
    localparam logic [4:0] S_M3   = 5'd4;   // final sum, round, saturate
    localparam logic [4:0] S_DU   = 5'd5;   // start u = dt*2^16 / tau
    localparam logic [4:0] S_DUW  = 5'd6;
    localparam logic [4:0] S_H1   = 5'd7;   // Horner: t * f
    localparam logic [4:0] S_H2   = 5'd8;   // Horner: / k by reciprocal
    localparam logic [4:0] S_H3   = 5'd9;   // Horner: 1 - quotient
    localparam logic [4:0] S_E    = 5'd10;  // integer part: t * exp(-1)
    localparam logic [4:0] S_E2   = 5'd11;
    localparam logic [4:0] S_ER   = 5'd12;  // round t to Q0.16 -> w
    localparam logic [4:0] S_V    = 5'd13;  // (1 - w) * tau
    localparam logic [4:0] S_VS   = 5'd14;  // start v division by dt
    localparam logic [4:0] S_VW   = 5'd15;
    localparam logic [4:0] S_FIN  = 5'd16;  // hand result to output register

    localparam int W_W = emarif_pkg::W_W;

    // configuration
    logic        mode_reg;
    logic [31:0] smoothing_reg;

    // filter state
    logic [31:0] ema_reg, ema_next;
    logic [31:0] prev_reg, prev_next;
    logic [31:0] ltime_reg, ltime_next;
    logic        started_reg, started_next;

    // request working set
    logic [4:0]  state_reg, state_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] dt_reg, dt_next;
    logic [31:0] res_reg, res_next;
    logic [W_W-1:0] coef0_reg, coef0_next;
    logic [W_W-1:0] coef1_reg, coef1_next;
    logic [W_W-1:0] coef2_reg, coef2_next;
    logic [W_W-1:0] w_reg, w_next;
    logic signed [emarif_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [31:0] t_reg, t_next;
    logic [15:0] f_reg, f_next;
    logic [3:0]  n_reg, n_next;
    logic [3:0]  k_reg, k_next;

    // output register
    logic        ovalid_reg, ovalid_next;
    logic [31:0] odata_reg, odata_next;

    // shared multiplier, registered product
    logic signed [emarif_pkg::MUL_A_W-1:0] mul_a;
    logic signed [emarif_pkg::MUL_B_W-1:0] mul_b;
    logic signed [emarif_pkg::PROD_W-1:0]  prod_reg;

    // shared divider
    logic                               div_start;
    logic [emarif_pkg::DIV_N_W-1:0]     div_dividend;
    logic [emarif_pkg::DIV_D_W-1:0]     div_divisor;
    logic                               div_done;
    logic [emarif_pkg::DIV_N_W-1:0]     div_q;

    // local scratch
    logic [31:0]        dt_in;
    logic [W_W-1:0]     a_sat;
    logic [W_W-1:0]     v_tmp;
    logic [32:0]        t_rnd;
    logic [63:0]        e_rnd;
    logic signed [emarif_pkg::ACC_W-1:0] sum_fin;

    emarif_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign average   = odata_reg;

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M0:
            begin
                mul_a = {20'b0, coef0_reg};
                mul_b = {x_reg[31], x_reg};
            end
            S_M1:
            begin
                mul_a = {20'b0, coef1_reg};
                mul_b = {ema_reg[31], ema_reg};
            end
            S_M2:
            begin
                mul_a = {20'b0, coef2_reg};
                mul_b = {prev_reg[31], prev_reg};
            end
            S_H1:
            begin
                mul_a = {5'b0, t_reg};
                mul_b = {17'b0, f_reg};
            end
            S_H2:
            begin
                mul_a = {1'b0, emarif_pkg::recip_k(k_reg)};
                mul_b = {1'b0, prod_reg[47:16]};
            end
            S_E:
            begin
                mul_a = {5'b0, t_reg};
                mul_b = {3'b0, emarif_pkg::EXP_M1_Q31};
            end
            S_V:
            begin
                mul_a = {20'b0, emarif_pkg::WONE - w_reg};
                mul_b = {1'b0, smoothing_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider hookup: u in S_DU, v in S_VS
    always_comb
    begin
        div_start    = (state_reg == S_DU) || (state_reg == S_VS);
        div_dividend = (state_reg == S_DU) ? {1'b0, dt_reg, 16'b0}
                                           : prod_reg[emarif_pkg::DIV_N_W-1:0];
        div_divisor  = (state_reg == S_DU) ? smoothing_reg : dt_reg;
    end

    // sequencer and datapath
    always_comb
    begin
        state_next   = state_reg;
        ema_next     = ema_reg;
        prev_next    = prev_reg;
        ltime_next   = ltime_reg;
        started_next = started_reg;
        x_next       = x_reg;
        ts_next      = ts_reg;
        dt_next      = dt_reg;
        res_next     = res_reg;
        coef0_next   = coef0_reg;
        coef1_next   = coef1_reg;
        coef2_next   = coef2_reg;
        w_next       = w_reg;
        acc_next     = acc_reg;
        t_next       = t_reg;
        f_next       = f_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;

        dt_in   = timestamp - ltime_reg;
        a_sat   = (smoothing_reg > 32'd65536) ? emarif_pkg::WONE : smoothing_reg[W_W-1:0];
        v_tmp   = '0;
        t_rnd   = {1'b0, t_reg} + 33'd16384;
        e_rnd   = prod_reg[63:0] + 64'h4000_0000;
        sum_fin = acc_reg + prod_reg[emarif_pkg::ACC_W-1:0];

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next  = sample;
                    ts_next = timestamp;
                    dt_next = dt_in;
                    if (!started_reg)
                    begin
                        res_next   = sample;
                        state_next = S_FIN;
                    end
                    else if (!mode_reg)
                    begin
                        // regular: a*x + (1-a)*ema
                        coef0_next = a_sat;
                        coef1_next = emarif_pkg::WONE - a_sat;
                        coef2_next = '0;
                        state_next = S_M0;
                    end
                    else if (dt_in == 32'd0)
                    begin
                        res_next   = ema_reg;       // hold the old average
                        state_next = S_FIN;
                    end
                    else if (smoothing_reg == 32'd0)
                    begin
                        res_next   = sample;        // infinite u: w = v = 0
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DU;
                    end
                end
            end
            S_M0: state_next = S_M1;
            S_M1:
            begin
                acc_next   = prod_reg[emarif_pkg::ACC_W-1:0];
                state_next = S_M2;
            end
            S_M2:
            begin
                acc_next   = acc_reg + prod_reg[emarif_pkg::ACC_W-1:0];
                state_next = S_M3;
            end
            S_M3:
            begin
                res_next   = emarif_pkg::round_sat(sum_fin);
                state_next = S_FIN;
            end
            S_DU: state_next = S_DUW;
            S_DUW:
            begin
                if (div_done)
                begin
                    if (div_q[48:16] >= {29'b0, emarif_pkg::EXP_INT_LIMIT})
                    begin
                        w_next     = '0;
                        state_next = S_V;
                    end
                    else
                    begin
                        n_next     = div_q[19:16];
                        f_next     = div_q[15:0];
                        t_next     = emarif_pkg::Q31ONE;
                        k_next     = emarif_pkg::HORNER_TERMS;
                        state_next = S_H1;
                    end
                end
            end
            S_H1: state_next = S_H2;
            S_H2: state_next = S_H3;
            S_H3:
            begin
                t_next = emarif_pkg::Q31ONE - prod_reg[66:35];
                if (k_reg == 4'd1)
                    state_next = S_E;
                else
                begin
                    k_next     = k_reg - 4'd1;
                    state_next = S_H1;
                end
            end
            S_E:
            begin
                if (n_reg == 4'd0)
                    state_next = S_ER;
                else
                    state_next = S_E2;
            end
            S_E2:
            begin
                t_next     = e_rnd[62:31];
                n_next     = n_reg - 4'd1;
                state_next = S_E;
            end
            S_ER:
            begin
                if (t_rnd[32:15] > {1'b0, emarif_pkg::WONE})
                    w_next = emarif_pkg::WONE;
                else
                    w_next = t_rnd[31:15];
                state_next = S_V;
            end
            S_V:  state_next = S_VS;
            S_VS: state_next = S_VW;
            S_VW:
            begin
                if (div_done)
                begin
                    // clamp v into [w, 1]
                    if (div_q > {32'b0, emarif_pkg::WONE})
                        v_tmp = emarif_pkg::WONE;
                    else
                        v_tmp = div_q[W_W-1:0];
                    if (v_tmp < w_reg)
                        v_tmp = w_reg;
                    coef0_next = emarif_pkg::WONE - v_tmp;
                    coef1_next = w_reg;
                    coef2_next = v_tmp - w_reg;
                    state_next = S_M0;
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next  = 1'b1;
                    odata_next   = res_reg;
                    ema_next     = res_reg;
                    prev_next    = x_reg;
                    ltime_next   = ts_reg;
                    started_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            smoothing_reg <= 32'd32768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                emarif_pkg::REG_MODE:      mode_reg      <= cfg_data[0];
                emarif_pkg::REG_SMOOTHING: smoothing_reg <= cfg_data;
                default:                   mode_reg      <= mode_reg;
            endcase
        end
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ovalid_reg  <= 1'b0;
            started_reg <= 1'b0;
            ema_reg     <= '0;
            prev_reg    <= '0;
            ltime_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
            started_reg <= started_next;
            ema_reg     <= ema_next;
            prev_reg    <= prev_next;
            ltime_reg   <= ltime_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        ts_reg    <= ts_next;
        dt_reg    <= dt_next;
        res_reg   <= res_next;
        coef0_reg <= coef0_next;
        coef1_reg <= coef1_next;
        coef2_reg <= coef2_next;
        w_reg     <= w_next;
        acc_reg   <= acc_next;
        t_reg     <= t_next;
        f_reg     <= f_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        odata_reg <= odata_next;
        prod_reg  <= mul_a * mul_b;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while the previous one is still running");
    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DUW) || (state_reg == S_VW))
        else $error("division finished outside a wait state");
    a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && !ovalid_reg |=> ovalid_reg && (state_reg == S_IDLE))
        else $error("result not handed to the output register");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #10 clk = ~clk;

    // Block ports
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] sample = '0;
    logic        [31:0] timestamp = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] average;
    logic               cfg_we = 1'b0;
    logic               cfg_index = emarif_pkg::REG_MODE;
    logic        [31:0] cfg_data = '0;

    ema_regular_irregular_filter_top DUT (.*);

    // Predictor's own copy of registers and state
    logic        pm_mode;
    logic [31:0] pm_smooth;
    logic [31:0] pm_avg;
    logic [31:0] pm_last_x;
    logic [31:0] pm_last_t;
    logic        pm_seeded;

    logic [31:0] avg_queue[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          tail_phase = 1'b0;
    localparam int WATCHDOG = 20000;

    // Round off 16 fraction bits half up, then clamp to 32 bits signed
    function automatic logic [31:0] sum_to_q16(input longint s);
        longint r;
        r = (s + 64'sd32768) >>> 16;
        if (r > 64'sd2147483647)  return 32'h7FFF_FFFF;
        if (r < -64'sd2147483648) return 32'h8000_0000;
        return r[31:0];
    endfunction

    // exp(-u), u in Q16.16, answer as Q0.16 weight
    function automatic logic [63:0] decay_weight(input logic [63:0] u);
        logic [63:0] n, f, t;
        n = u >> 16;
        f = u & 64'hFFFF;
        t = 64'h8000_0000;
        if (n >= 12) return 64'd0;
        for (int k = 8; k >= 1; k--)
            t = 64'h8000_0000 - ((t * f) >> 16) / k;
        for (int k = 0; k < n; k++)
            t = (t * 64'd790015084 + (64'd1 << 30)) >> 31;
        t = (t + (64'd1 << 14)) >> 15;
        return (t > 65536) ? 64'd65536 : t;
    endfunction

    // Next average for one request; updates predictor state
    function automatic logic [31:0] next_average(input logic [31:0] xs, input logic [31:0] ts);
        longint      x, ema, prev;
        logic [63:0] a, u, w, v, tau;
        logic [31:0] dt, res;
        x = longint'($signed(xs));
        ema = longint'($signed(pm_avg));
        if (!pm_seeded)
            res = xs;
        else if (pm_mode == 1'b0) begin
            a = (pm_smooth > 65536) ? 64'd65536 : 64'(pm_smooth);
            res = sum_to_q16(longint'(a) * x + longint'(65536 - a) * ema);
        end else begin
            dt = ts - pm_last_t;
            tau = 64'(pm_smooth);
            if (dt == 0)
                res = pm_avg;
            else if (tau == 0)
                res = xs;
            else begin
                u = (64'(dt) << 16) / tau;
                w = decay_weight(u);
                v = ((65536 - w) * tau) / 64'(dt);
                prev = longint'($signed(pm_last_x));
                if (v > 65536) v = 65536;
                if (v < w) v = w;
                res = sum_to_q16(longint'(w) * ema + longint'(v - w) * prev
                                 + longint'(65536 - v) * x);
            end
        end
        pm_seeded = 1'b1;
        pm_avg = res;
        pm_last_x = xs;
        pm_last_t = ts;
        return res;
    endfunction

    // Idle burst now and then, none in the tail
    task automatic maybe_gap();
        if (!tail_phase && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Present one request, hold until accepted; known is optional typed-in result.
    // Valid stays up after the accept so back-to-back requests need no gap.
    task automatic send_request(input logic [31:0] xs, input logic [31:0] ts,
                                input bit has_known, input logic [31:0] known);
        logic [31:0] predicted;
        maybe_gap();
        in_valid  <= 1'b1;
        sample    <= xs;
        timestamp <= ts;
        do @(posedge clk); while (!in_ready);
        predicted = next_average(xs, ts);
        if (has_known && known !== predicted)
            $display("note: table row %h disagrees with predictor %h", known, predicted);
        avg_queue.push_back(has_known ? known : predicted);
    endtask

    // Configuration write, only while idle
    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == emarif_pkg::REG_MODE) pm_mode = val[0];
        else                             pm_smooth = val;
        @(posedge clk);
    endtask

    // Wait until all results are back, then a latency's worth of settling
    task automatic drain();
        in_valid <= 1'b0;
        while (avg_queue.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Result side: random stalls, compare against the oldest expectation
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (avg_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", average);
                end else begin
                    logic [31:0] want;
                    want = avg_queue.pop_front();
                    if (average !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("average mismatch: expected %h got %h", want, average);
                    end
                end
            end
            if (tail_phase)
                out_ready <= 1'b1;
            else if (!out_ready) begin
                if (stall_left == 0)
                    out_ready <= 1'b1;
                else
                    stall_left <= stall_left - 1;
            end else if ($urandom_range(0, 4) == 0) begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(0, 5);
            end
        end
    end

    // Watchdog: cycles with no request or result moving
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Directed table: sample, timestamp, whether the result is typed in, the result
    typedef struct {
        logic [31:0] x;
        logic [31:0] t;
        bit          known_ok;
        logic [31:0] known;
    } row_t;

    row_t dir_rows[$];
    logic [31:0] tnow;
    logic [31:0] tau_pick[6] = '{32'd1, 32'd7, 32'd100, 32'd4096, 32'hFFFF_FFFF, 32'd0};

    initial begin
        pm_mode = 1'b0; pm_smooth = 32'd32768; pm_avg = '0;
        pm_last_x = '0; pm_last_t = '0; pm_seeded = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Regular mode at reset weight: first sample passes straight through
        dir_rows = '{
            '{32'h8000_0000, 32'd0, 1'b1, 32'h8000_0000},   // seeding, most negative
            '{32'h7FFF_FFFF, 32'd5, 1'b0, 32'd0},
            '{32'h7FFF_FFFF, 32'd5, 1'b0, 32'd0},
            '{32'h0001_0000, 32'd6, 1'b0, 32'd0}
        };
        foreach (dir_rows[i])
            send_request(dir_rows[i].x, dir_rows[i].t, dir_rows[i].known_ok, dir_rows[i].known);
        drain();

        // Weight one (and above one, which saturates): output equals sample
        write_reg(emarif_pkg::REG_SMOOTHING, 32'd65536);
        send_request(32'h1234_5678, 32'd7, 1'b1, 32'h1234_5678);
        drain();
        write_reg(emarif_pkg::REG_SMOOTHING, 32'hFFFF_FFFF);
        send_request(32'hDEAD_BEEF, 32'd8, 1'b1, 32'hDEAD_BEEF);
        drain();
        write_reg(emarif_pkg::REG_SMOOTHING, 32'd1);
        send_request(32'h7FFF_FFFF, 32'd9, 1'b0, 32'd0);
        drain();

        // Irregular mode: zero step holds, zero tau passes, wrap, big steps
        write_reg(emarif_pkg::REG_MODE, 1'b1);
        write_reg(emarif_pkg::REG_SMOOTHING, 32'd100);
        send_request(32'h0005_0000, 32'd9, 1'b0, 32'd0);            // zero step
        send_request(32'h0010_0000, 32'd59, 1'b0, 32'd0);
        send_request(32'hFFF0_0000, 32'hFFFF_FFF0, 1'b0, 32'd0);   // long step
        send_request(32'h7FFF_FFFF, 32'd20, 1'b0, 32'd0);          // wraps
        send_request(32'h8000_0000, 32'd21, 1'b0, 32'd0);
        drain();
        write_reg(emarif_pkg::REG_SMOOTHING, 32'd0);
        send_request(32'h0ABC_0000, 32'd40, 1'b1, 32'h0ABC_0000);  // zero tau
        drain();
        write_reg(emarif_pkg::REG_SMOOTHING, 32'hFFFF_FFFF);
        send_request(32'h0003_0000, 32'd41, 1'b0, 32'd0);
        send_request(32'h0004_0000, 32'hFFFF_FFFF, 1'b0, 32'd0);
        drain();

        // Random phases: several settings of both registers
        for (int ph = 0; ph < 26; ph++) begin
            write_reg(emarif_pkg::REG_MODE, ph[0]);
            if (ph[0])
                write_reg(emarif_pkg::REG_SMOOTHING,
                          ($urandom_range(0, 1)) ? tau_pick[$urandom_range(0, 5)]
                                                 : $urandom());
            else
                write_reg(emarif_pkg::REG_SMOOTHING,
                          ($urandom_range(0, 3) == 0) ? $urandom()
                                                      : $urandom_range(1, 65536));
            tnow = $urandom();
            if (ph >= 22) tail_phase = 1'b1;
            for (int i = 0; i < 50; i++) begin
                logic [31:0] xs;
                case ($urandom_range(0, 5))
                    0:       xs = $urandom();
                    1:       xs = ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: xs = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
                endcase
                case ($urandom_range(0, 7))
                    0:       tnow = tnow;                            // zero step
                    1:       tnow = $urandom();                      // anything, may wrap
                    2:       tnow = tnow + $urandom_range(1, 2000);
                    default: tnow = tnow + $urandom_range(1, 300);
                endcase
                send_request(xs, tnow, 1'b0, 32'd0);
            end
            // Hold off until everything outstanding is back before reconfiguring
            drain();
        end

        drain();
        if (mismatches == 0 && avg_queue.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
